/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/sfd_pkg.sv */
`timescale 1ns / 1ps
package sfd_pkg;

  localparam int COMP_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;
  localparam int DIST_BITS      = 18;
  localparam int ERR_SHIFT      = 10;
  localparam int TAG_BITS       = 16;

  // commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_FRAME = 2'd1;
  localparam logic [1:0] CMD_PIXEL = 2'd2;
  localparam logic [1:0] CMD_SPARE = 2'd3;  // no action

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_LINE_WIDTH    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PALETTE_COUNT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_VALUE     = 2'd2;

  // error weights in sixteenths
  localparam logic [3:0] WT_AHEAD = 4'd7;
  localparam logic [3:0] WT_BACK  = 4'd3;
  localparam logic [3:0] WT_BELOW = 4'd5;
  localparam logic [3:0] WT_DIAG  = 4'd1;

  // first epoch value at which an advance starts a sweep instead
  localparam logic [TAG_BITS-1:0] TAG_LIMIT = 16'hFFFC;

endpackage

/* hw/rtl/sfd_pix_if.sv */
`timescale 1ns / 1ps
interface sfd_pix_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     cmd;
  logic [7:0]                     entry_index;
  logic [sfd_pkg::COMP_BITS-1:0]  in_red;
  logic [sfd_pkg::COMP_BITS-1:0]  in_green;
  logic [sfd_pkg::COMP_BITS-1:0]  in_blue;

  modport source (output valid, cmd, entry_index, in_red, in_green, in_blue, input ready);
  modport sink (input valid, cmd, entry_index, in_red, in_green, in_blue, output ready);
endinterface

/* hw/rtl/sfd_res_if.sv */
`timescale 1ns / 1ps
interface sfd_res_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     palette_index;
  logic [sfd_pkg::COMP_BITS-1:0]  out_red;
  logic [sfd_pkg::COMP_BITS-1:0]  out_green;
  logic [sfd_pkg::COMP_BITS-1:0]  out_blue;
  logic                           row_end;

  modport source (output valid, palette_index, out_red, out_green, out_blue, row_end,
                  input ready);
  modport sink (input valid, palette_index, out_red, out_green, out_blue, row_end,
                output ready);
endinterface

/* hw/rtl/sfd_cfg_if.sv */
`timescale 1ns / 1ps
interface sfd_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [sfd_pkg::CFG_INDEX_BITS-1:0]   index;
  logic [sfd_pkg::CFG_DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/serpentine_fs_dither_palette_map.sv */
`timescale 1ns / 1ps
// Serpentine Floyd-Steinberg ditherer with nearest-palette mapping. Beats on pixel_in carry
// a command: load one palette slot, start a frame, or a pixel; each pixel beat gives one beat
// on pixel_out with the chosen index, its colour and a row-end flag. A load is handled in the
// idle state, as is a frame start unless it starts a sweep. A pixel passes through an
// error-line read, an adjust step, a walk of the palette memory at one entry per cycle with
// a pipeline drain, four read-modify-write passes on the error memory and an output step,
// which waits while the previous result beat is still held, and the next beat is taken once
// the block is idle again. Both error lines live in one memory tagged with a row epoch, so
// row ends and frame starts cost nothing; after reset, and when the epoch runs out (about
// every 64k rows or 32k frame starts), a pass walks all 2*2^clog2(MAX_LINE+2) error entries
// while no pixel beat is taken. At a row end that pass keeps the next line and retags it;
// otherwise it clears everything. Configuration writes are always taken and must only come
// while idle.
`include "assert_macros.svh"
module serpentine_fs_dither_palette_map #(
  parameter int MAX_PALETTE = 256,
  parameter int MAX_LINE    = 2048,
  parameter int ERROR_BITS  = 20
) (
  input  logic       clk,
  input  logic       rst,
  sfd_pix_if.sink    pixel_in,
  sfd_res_if.source  pixel_out,
  sfd_cfg_if.sink    cfg
);

  localparam int CW  = $clog2(MAX_LINE + 2);       // error cell index bits
  localparam int AW  = CW + 1;                     // bank bit plus cell
  localparam int PW  = $clog2(MAX_PALETTE);        // palette address bits
  localparam int XW  = ((CW > 12) ? CW : 12) + 1;  // width for clamping line width
  localparam int TB  = sfd_pkg::TAG_BITS;
  localparam int EB  = ERROR_BITS;
  localparam int MW  = TB + 3 * EB;
  localparam int DB  = sfd_pkg::DIST_BITS;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_RD_CUR = 8'b0000_0010,
    ST_ADJ    = 8'b0000_0100,
    ST_SEARCH = 8'b0000_1000,
    ST_SP_RD  = 8'b0001_0000,
    ST_SP_WR  = 8'b0010_0000,
    ST_FINISH = 8'b0100_0000,
    ST_SWEEP  = 8'b1000_0000
  } state_t;

  state_t state;

  // configuration registers
  logic [11:0] line_width;
  logic [8:0]  palette_count;
  logic [7:0]  max_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= 12'd2048;
      palette_count <= 9'd256;
      max_value     <= 8'd255;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sfd_pkg::REG_LINE_WIDTH:    line_width    <= cfg.data;
        sfd_pkg::REG_PALETTE_COUNT: palette_count <= cfg.data[8:0];
        sfd_pkg::REG_MAX_VALUE:     max_value     <= cfg.data[7:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // effective width and palette count: zero acts as one, large values saturate
  logic [XW-1:0] lw_x;
  logic [CW-1:0] w_eff;
  logic [8:0]    n_9;
  logic [PW:0]   n_eff;

  always_comb begin
    if (line_width == 12'd0)                lw_x = XW'(1);
    else if (XW'(line_width) > XW'(MAX_LINE)) lw_x = XW'(MAX_LINE);
    else                                    lw_x = XW'(line_width);
    w_eff = CW'(lw_x);
    if (palette_count == 9'd0)                 n_9 = 9'd1;
    else if (palette_count > 9'(MAX_PALETTE))  n_9 = 9'(MAX_PALETTE);
    else                                       n_9 = palette_count;
    n_eff = (PW + 1)'(n_9);
  end

  // row position
  logic [CW-1:0] pos;
  logic          rev;
  logic [CW-1:0] pos_c;
  logic [CW-1:0] col_c;
  logic          last_c;

  always_comb begin
    pos_c  = (pos >= w_eff) ? w_eff - CW'(1) : pos;
    col_c  = rev ? (w_eff - CW'(1) - pos_c) : pos_c;
    last_c = ({1'b0, pos_c} + (CW + 1)'(1)) >= {1'b0, w_eff};
  end

  // latched pixel
  logic [CW-1:0] col_r;
  logic          last_r;
  logic [7:0]    comp_r [3];
  logic [7:0]    adj    [3];

  // row epoch tags the error memory; current line bank = epoch[0]
  logic [TB-1:0] epoch;
  logic [AW-1:0] sw;
  logic [AW-1:0] sw_q;
  logic          sw_v;
  logic          sweep_end;
  logic          sweep_keep;
  logic          cur_bank;
  logic [TB-1:0] rebase_tag;
  assign cur_bank   = epoch[0];
  // a row-end pass moves the next line to a low epoch of the same bank parity
  assign rebase_tag = {{(TB-1){1'b0}}, ~cur_bank};

  // palette memory
  logic [23:0]   pal_mem [MAX_PALETTE];
  logic [23:0]   pal_q;
  logic [PW:0]   iss;
  logic [PW-1:0] pal_addr;
  logic          in_fire;
  logic          load_ok;

  assign in_fire  = pixel_in.valid && pixel_in.ready;
  assign load_ok  = in_fire && (pixel_in.cmd == sfd_pkg::CMD_LOAD) &&
                    ({1'b0, pixel_in.entry_index} < 9'(MAX_PALETTE));
  assign pal_addr = iss[PW-1:0];

  always_ff @(posedge clk) begin
    if (load_ok)
      pal_mem[pixel_in.entry_index[PW-1:0]] <=
        {pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue};
    pal_q <= pal_mem[pal_addr];
  end

  // error memory: {tag, red, green, blue}
  logic [MW-1:0] err_mem [2**AW];
  logic [MW-1:0] err_q;
  logic [AW-1:0] err_ra;
  logic [AW-1:0] err_wa;
  logic [MW-1:0] err_wd;
  logic          err_we;

  always_ff @(posedge clk) begin
    if (err_we) err_mem[err_wa] <= err_wd;
    err_q <= err_mem[err_ra];
  end

  // spread step select
  logic [1:0]    step;
  logic [CW-1:0] step_cell;
  logic          step_bank;
  logic [TB-1:0] step_tag;
  logic [3:0]    step_wt;
  logic [AW-1:0] step_addr;
  logic [AW-1:0] adj_addr;

  always_comb begin
    unique case (step)
      2'd0: begin
        step_cell = rev ? col_r : col_r + CW'(2);
        step_bank = cur_bank;
        step_tag  = epoch;
        step_wt   = sfd_pkg::WT_AHEAD;
      end
      2'd1: begin
        step_cell = rev ? col_r + CW'(2) : col_r;
        step_bank = ~cur_bank;
        step_tag  = epoch + TB'(1);
        step_wt   = sfd_pkg::WT_BACK;
      end
      2'd2: begin
        step_cell = col_r + CW'(1);
        step_bank = ~cur_bank;
        step_tag  = epoch + TB'(1);
        step_wt   = sfd_pkg::WT_BELOW;
      end
      default: begin
        step_cell = rev ? col_r : col_r + CW'(2);
        step_bank = ~cur_bank;
        step_tag  = epoch + TB'(1);
        step_wt   = sfd_pkg::WT_DIAG;
      end
    endcase
    step_addr = {step_bank, step_cell};
    adj_addr  = {cur_bank, col_r + CW'(1)};
    if (state == ST_SWEEP)       err_ra = sw;
    else if (state == ST_RD_CUR) err_ra = adj_addr;
    else                         err_ra = step_addr;
  end

  // best candidate
  logic [DB-1:0] best_d;
  logic [PW-1:0] best_idx;
  logic [23:0]   best_rgb;

  // error update: delta = (adj - chosen) * 1024 * weight / 16, exact as * weight * 64
  logic          old_ok;
  logic [MW-1:0] upd_word;

  always_comb begin
    logic signed [8:0]    diff;
    logic signed [12:0]   prod;
    logic signed [EB-1:0] delta;
    logic signed [EB-1:0] old_v;
    old_ok = (err_q[MW-1 -: TB] == step_tag);
    upd_word = '0;
    upd_word[MW-1 -: TB] = step_tag;
    for (int k = 0; k < 3; k++) begin
      diff  = $signed({1'b0, adj[k]}) - $signed({1'b0, best_rgb[(2-k)*8 +: 8]});
      prod  = diff * $signed({1'b0, step_wt});
      delta = EB'($signed({prod, 6'b0}));
      old_v = old_ok ? $signed(err_q[(2-k)*EB +: EB]) : '0;
      upd_word[(2-k)*EB +: EB] = old_v + delta;
    end
  end

  // sweep write: live next-line entries survive a row-end pass, all else clears
  logic          sweep_hold;
  logic [MW-1:0] sweep_word;

  always_comb begin
    sweep_hold = sweep_keep && (sw_q[AW-1] == ~cur_bank) &&
                 (err_q[MW-1 -: TB] == epoch + TB'(1));
    sweep_word = sweep_hold ? {rebase_tag, err_q[3*EB-1:0]} : '0;
    err_we = 1'b0;
    err_wa = step_addr;
    err_wd = upd_word;
    if (state == ST_SWEEP) begin
      err_we = sw_v;
      err_wa = sw_q;
      err_wd = sweep_word;
    end else if (state == ST_SP_WR) begin
      err_we = 1'b1;
    end
  end

  // adjusted components: carried error / 1024 toward zero, then clamp
  logic [7:0] adj_c [3];

  always_comb begin
    logic signed [EB-1:0] v;
    logic signed [EB-1:0] q;
    logic signed [EB:0]   s;
    for (int k = 0; k < 3; k++) begin
      v = (err_q[MW-1 -: TB] == epoch) ? $signed(err_q[(2-k)*EB +: EB]) : '0;
      q = (v + (v[EB-1] ? EB'(1023) : EB'(0))) >>> sfd_pkg::ERR_SHIFT;
      s = $signed({1'b0, EB'(comp_r[k])}) + (EB + 1)'(q);
      if (s < 0)                            adj_c[k] = 8'd0;
      else if (s > $signed((EB + 1)'(max_value))) adj_c[k] = max_value;
      else                                  adj_c[k] = s[7:0];
    end
  end

  // distance stage
  logic          v1;
  logic          v2;
  logic [PW-1:0] idx1;
  logic [PW-1:0] idx2;
  logic [DB-1:0] d2;
  logic [23:0]   rgb2;
  logic [DB-1:0] dist_c;

  always_comb begin
    logic signed [8:0]  t;
    logic signed [17:0] sq;
    dist_c = '0;
    for (int k = 0; k < 3; k++) begin
      t      = $signed({1'b0, adj[k]}) - $signed({1'b0, pal_q[(2-k)*8 +: 8]});
      sq     = t * t;
      dist_c = dist_c + DB'(sq);
    end
  end

  // output register
  logic       out_valid;
  logic       out_free;
  logic [7:0] out_idx;
  logic [23:0] out_rgb;
  logic       out_end;

  assign out_free = !out_valid || pixel_out.ready;
  assign pixel_out.valid         = out_valid;
  assign pixel_out.palette_index = out_idx;
  assign pixel_out.out_red       = out_rgb[23:16];
  assign pixel_out.out_green     = out_rgb[15:8];
  assign pixel_out.out_blue      = out_rgb[7:0];
  assign pixel_out.row_end       = out_end;

  assign pixel_in.ready = (state == ST_IDLE);

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      col_r     <= col_c;
      last_r    <= last_c;
      comp_r[0] <= pixel_in.in_red;
      comp_r[1] <= pixel_in.in_green;
      comp_r[2] <= pixel_in.in_blue;
    end
    if (state == ST_ADJ) begin
      adj    <= adj_c;
      best_d <= '1;  // above any real distance, so entry zero always lands
    end
    if (v1) begin
      d2   <= dist_c;
      idx2 <= idx1;
      rgb2 <= pal_q;
    end
    if (state == ST_SEARCH) begin
      idx1 <= pal_addr;
      // strict compare keeps the lowest index on a tie
      if (v2 && d2 < best_d) begin
        best_d   <= d2;
        best_idx <= idx2;
        best_rgb <= rgb2;
      end
    end
    if (state == ST_FINISH && out_free) begin
      out_idx <= 8'(best_idx);
      out_rgb <= best_rgb;
      out_end <= last_r;
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sw         <= '0;
      sw_q       <= '0;
      sw_v       <= 1'b0;
      sweep_end  <= 1'b0;
      sweep_keep <= 1'b0;
      epoch      <= '0;
      pos        <= '0;
      rev        <= 1'b0;
      iss        <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      step       <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (state == ST_FINISH && out_free) out_valid <= 1'b1;
      else if (pixel_out.ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (pixel_in.cmd == sfd_pkg::CMD_FRAME) begin
              pos <= '0;
              rev <= 1'b0;
              // both lines go stale by jumping two epochs
              if (epoch >= sfd_pkg::TAG_LIMIT) begin
                sweep_keep <= 1'b0;
                state      <= ST_SWEEP;
              end else epoch <= epoch + TB'(2);
            end else if (pixel_in.cmd == sfd_pkg::CMD_PIXEL) begin
              state <= ST_RD_CUR;
            end
          end
        end
        ST_RD_CUR: state <= ST_ADJ;
        ST_ADJ: begin
          iss   <= '0;
          v1    <= 1'b0;
          v2    <= 1'b0;
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (iss != n_eff) begin
            v1  <= 1'b1;
            iss <= iss + (PW + 1)'(1);
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          if (iss == n_eff && !v1 && !v2) begin
            step  <= 2'd0;
            state <= ST_SP_RD;
          end
        end
        ST_SP_RD: state <= ST_SP_WR;
        ST_SP_WR: begin
          step <= step + 2'd1;
          if (step == 2'd3) state <= ST_FINISH;
          else state <= ST_SP_RD;
        end
        ST_FINISH: begin
          if (out_free) begin
            if (last_r) begin
              // next line becomes current by advancing the epoch
              pos <= '0;
              rev <= ~rev;
              if (epoch >= sfd_pkg::TAG_LIMIT) begin
                sweep_keep <= 1'b1;
                state      <= ST_SWEEP;
              end else begin
                epoch <= epoch + TB'(1);
                state <= ST_IDLE;
              end
            end else begin
              pos   <= pos_c + CW'(1);
              state <= ST_IDLE;
            end
          end
        end
        ST_SWEEP: begin
          // read one entry per cycle, write it back in the cycle after
          if (sweep_end) begin
            sw_v      <= 1'b0;
            sweep_end <= 1'b0;
            epoch     <= sweep_keep ? rebase_tag : '0;
            state     <= ST_IDLE;
          end else begin
            sw   <= sw + AW'(1);
            sw_q <= sw;
            sw_v <= 1'b1;
            if (sw == '1) sweep_end <= 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  `ASSERT_NEXT(a_finish_drives_out, clk, rst, (state == ST_FINISH) && out_free, pixel_out.valid, "finished pixel not presented")
  `ASSERT_IMPLIES(a_issue_bound, clk, rst, state == ST_SEARCH, iss <= n_eff, "palette walk ran past count")
  `ASSERT_IMPLIES(a_epoch_bound, clk, rst, 1'b1, epoch <= sfd_pkg::TAG_LIMIT + TB'(1), "epoch past limit")

endmodule

/* dv/serpentine_fs_dither_palette_map_tb.sv */
`timescale 1ns / 1ps
module serpentine_fs_dither_palette_map_tb;

  localparam int PAL_DEPTH = 256;
  localparam int LINE_MAX  = 2048;
  localparam int ERR_W     = 20;
  localparam int CELL_N    = LINE_MAX + 2;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] slot;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       last;
  } map_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sfd_pix_if pixel_in ();
  sfd_res_if pixel_out ();
  sfd_cfg_if cfg ();

  serpentine_fs_dither_palette_map uut (
    .clk(clk),
    .rst(rst),
    .pixel_in(pixel_in),
    .pixel_out(pixel_out),
    .cfg(cfg)
  );

  always #2 clk = ~clk;

  // shadow of the dither state
  int unsigned sh_width, sh_count, sh_maxv;
  logic [7:0] sh_pal [PAL_DEPTH][3];
  int sh_cur [CELL_N][3];
  int sh_nxt [CELL_N][3];
  int unsigned sh_col;
  bit sh_rev;

  pix_beat_t pending_beats[$];
  map_beat_t expected_maps[$];
  int mismatches = 0;
  longint cycles = 0;
  bit long_hold = 1'b0;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  function automatic int wrap_err(input longint v);
    logic [ERR_W-1:0] t;
    t = v[ERR_W-1:0];
    return int'($signed(t));
  endfunction

  function automatic void clear_lines();
    for (int c = 0; c < CELL_N; c++)
      for (int k = 0; k < 3; k++) begin
        sh_cur[c][k] = 0;
        sh_nxt[c][k] = 0;
      end
  endfunction

  // predict the map beat for one command beat
  function automatic void dither_predict(input pix_beat_t p);
    int unsigned w, n, pos, col, best, c7, c3, c5, c1;
    int adj[3];
    int d, best_dist, t, e;
    map_beat_t m;
    if (p.cmd == sfd_pkg::CMD_LOAD) begin
      sh_pal[p.slot][0] = p.r;
      sh_pal[p.slot][1] = p.g;
      sh_pal[p.slot][2] = p.b;
      return;
    end
    if (p.cmd == sfd_pkg::CMD_FRAME) begin
      clear_lines();
      sh_col = 0;
      sh_rev = 1'b0;
      return;
    end
    if (p.cmd != sfd_pkg::CMD_PIXEL) return;
    w = (sh_width < 1) ? 1 : (sh_width > LINE_MAX ? LINE_MAX : sh_width);
    n = (sh_count < 1) ? 1 : (sh_count > PAL_DEPTH ? PAL_DEPTH : sh_count);
    pos = (sh_col >= w) ? w - 1 : sh_col;
    col = sh_rev ? (w - 1 - pos) : pos;
    adj[0] = int'(p.r) + sh_cur[col+1][0] / 1024;
    adj[1] = int'(p.g) + sh_cur[col+1][1] / 1024;
    adj[2] = int'(p.b) + sh_cur[col+1][2] / 1024;
    for (int k = 0; k < 3; k++) begin
      if (adj[k] < 0) adj[k] = 0;
      else if (adj[k] > int'(sh_maxv)) adj[k] = sh_maxv;
    end
    best = 0;
    best_dist = 2000000000;
    for (int i = 0; i < n; i++) begin
      d = 0;
      for (int k = 0; k < 3; k++) begin
        t = adj[k] - int'(sh_pal[i][k]);
        d += t * t;
      end
      if (d < best_dist) begin
        best_dist = d;
        best = i;
      end
    end
    // ahead/back cells swap with direction
    c7 = sh_rev ? col : col + 2;
    c3 = sh_rev ? col + 2 : col;
    c5 = col + 1;
    c1 = sh_rev ? col : col + 2;
    for (int k = 0; k < 3; k++) begin
      e = (adj[k] - int'(sh_pal[best][k])) * 1024;
      sh_cur[c7][k] = wrap_err(sh_cur[c7][k] + (e * 7) / 16);
      sh_nxt[c3][k] = wrap_err(sh_nxt[c3][k] + (e * 3) / 16);
      sh_nxt[c5][k] = wrap_err(sh_nxt[c5][k] + (e * 5) / 16);
      sh_nxt[c1][k] = wrap_err(sh_nxt[c1][k] + (e * 1) / 16);
    end
    m.idx = best[7:0];
    m.r = sh_pal[best][0];
    m.g = sh_pal[best][1];
    m.b = sh_pal[best][2];
    m.last = (pos + 1 >= w);
    if (m.last) begin
      sh_cur = sh_nxt;
      for (int c = 0; c < CELL_N; c++)
        for (int k = 0; k < 3; k++) sh_nxt[c][k] = 0;
      sh_rev = ~sh_rev;
      sh_col = 0;
    end else begin
      sh_col = pos + 1;
    end
    expected_maps.push_back(m);
  endfunction

  // driver: bursts of offered beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pixel_in.valid <= 1'b0;
    end else begin
      if (pixel_in.valid && pixel_in.ready) begin
        dither_predict(pending_beats.pop_front());
      end
      if (!(pixel_in.valid && !pixel_in.ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_in.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          pixel_in.valid       <= 1'b1;
          pixel_in.cmd         <= pending_beats[0].cmd;
          pixel_in.entry_index <= pending_beats[0].slot;
          pixel_in.in_red      <= pending_beats[0].r;
          pixel_in.in_green    <= pending_beats[0].g;
          pixel_in.in_blue     <= pending_beats[0].b;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 40);
          end
        end else begin
          pixel_in.valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, plus a long hold-off when asked
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      pixel_out.ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 97;
      if (long_hold) pixel_out.ready <= 1'b0;
      else if (stall_phase < 30) pixel_out.ready <= 1'b1;
      else pixel_out.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // monitor: compare each map beat with the oldest expectation
  always @(posedge clk) begin
    map_beat_t want;
    if (!rst) begin
      cycles++;
      if (pixel_out.valid && pixel_out.ready) begin
        if (expected_maps.size() == 0) begin
          report("unexpected beat", pixel_out.palette_index, -1);
        end else begin
          want = expected_maps.pop_front();
          if (pixel_out.palette_index !== want.idx)
            report("palette_index", pixel_out.palette_index, want.idx);
          if (pixel_out.out_red !== want.r) report("out_red", pixel_out.out_red, want.r);
          if (pixel_out.out_green !== want.g)
            report("out_green", pixel_out.out_green, want.g);
          if (pixel_out.out_blue !== want.b) report("out_blue", pixel_out.out_blue, want.b);
          if (pixel_out.row_end !== want.last)
            report("row_end", pixel_out.row_end, want.last);
        end
      end
      if (cycles > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() != 0 || pixel_in.valid || expected_maps.size() != 0)
      @(posedge clk);
    // a trailing load or frame start may still be in flight
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [sfd_pkg::CFG_INDEX_BITS-1:0] idx,
                           input int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val[sfd_pkg::CFG_DATA_BITS-1:0];
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      sfd_pkg::REG_LINE_WIDTH:    sh_width = val & 12'hFFF;
      sfd_pkg::REG_PALETTE_COUNT: sh_count = val & 9'h1FF;
      sfd_pkg::REG_MAX_VALUE:     sh_maxv  = val & 8'hFF;
      default: ;
    endcase
  endtask

  function automatic void queue_beat(input logic [1:0] c, input logic [7:0] s,
                                     input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
    pix_beat_t p;
    p.cmd = c; p.slot = s; p.r = r; p.g = g; p.b = b;
    pending_beats.push_back(p);
  endfunction

  function automatic void queue_pixel();
    queue_beat(sfd_pkg::CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  int cfg_w[6] = '{3, 1, 7, 0, 4095, 2048};
  int cfg_n[6] = '{16, 1, 256, 0, 511, 8};
  int cfg_m[6] = '{255, 1, 128, 0, 255, 200};

  initial begin
    pixel_in.valid = 1'b0;
    pixel_in.cmd = sfd_pkg::CMD_FRAME;
    pixel_in.entry_index = '0;
    pixel_in.in_red = '0;
    pixel_in.in_green = '0;
    pixel_in.in_blue = '0;
    pixel_out.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = sfd_pkg::REG_LINE_WIDTH;
    cfg.data = '0;
    sh_width = 2048; sh_count = 256; sh_maxv = 255;
    sh_col = 0; sh_rev = 1'b0;
    clear_lines();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // fill the whole palette so no unwritten slot is ever searched
    for (int i = 0; i < PAL_DEPTH; i++)
      queue_beat(sfd_pkg::CMD_LOAD, i[7:0], 8'($urandom), 8'($urandom), 8'($urandom));
    wait_drained();

    // directed: extremes, ties, unknown command, ignored commands
    write_reg(sfd_pkg::REG_LINE_WIDTH, 5);
    write_reg(sfd_pkg::REG_PALETTE_COUNT, 4);
    write_reg(sfd_pkg::REG_MAX_VALUE, 255);
    queue_beat(sfd_pkg::CMD_LOAD, 8'd0, 8'h00, 8'h00, 8'h00);
    queue_beat(sfd_pkg::CMD_LOAD, 8'd1, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(sfd_pkg::CMD_LOAD, 8'd2, 8'h80, 8'h80, 8'h80);
    queue_beat(sfd_pkg::CMD_LOAD, 8'd3, 8'h80, 8'h80, 8'h80); // duplicate colour, lower index wins
    queue_beat(sfd_pkg::CMD_FRAME, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(sfd_pkg::CMD_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00);
    queue_beat(sfd_pkg::CMD_PIXEL, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(sfd_pkg::CMD_PIXEL, 8'hAA, 8'h40, 8'h40, 8'h40); // equal distance to two entries
    queue_beat(sfd_pkg::CMD_SPARE, 8'h55, 8'hAA, 8'h55, 8'hAA);
    queue_beat(sfd_pkg::CMD_PIXEL, 8'h55, 8'h80, 8'h7F, 8'h81);
    queue_beat(sfd_pkg::CMD_PIXEL, 8'h0F, 8'hC0, 8'h20, 8'hF0);
    for (int i = 0; i < 6; i++) queue_pixel();
    queue_beat(sfd_pkg::CMD_FRAME, 8'd0, 8'd0, 8'd0, 8'd0);
    for (int i = 0; i < 3; i++) queue_pixel();
    wait_drained();
    // width shrunk in the middle of a row
    write_reg(sfd_pkg::REG_LINE_WIDTH, 2);
    for (int i = 0; i < 4; i++) queue_pixel();
    wait_drained();

    // random phases over several settings, with random palette loads
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(sfd_pkg::REG_LINE_WIDTH, cfg_w[ph]);
      write_reg(sfd_pkg::REG_PALETTE_COUNT, cfg_n[ph]);
      write_reg(sfd_pkg::REG_MAX_VALUE, cfg_m[ph]);
      queue_beat(sfd_pkg::CMD_FRAME, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      for (int i = 0; i < 178; i++) begin
        case ($urandom_range(0, 19))
          0: queue_beat(sfd_pkg::CMD_FRAME, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
          1, 2: queue_beat(sfd_pkg::CMD_LOAD, 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
          3: queue_beat(sfd_pkg::CMD_SPARE, 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom));
          default: queue_pixel();
        endcase
      end
      if (ph == 2) begin
        // hold the receiver off so the block backs up onto its input
        wait (expected_maps.size() != 0);
        long_hold = 1'b1;
        repeat (3000) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
